// ===== src/echo_reply_scoreboard_defines.svh =====
// Assertion macros shared by the scoreboard RTL.
`ifndef ECHO_REPLY_SCOREBOARD_DEFINES_SVH
`define ECHO_REPLY_SCOREBOARD_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define ESB_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("scoreboard check failed");

// Next-cycle implication, checked out of reset.
`define ESB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("scoreboard check failed");

`endif

// ===== src/esb_pkg.sv =====
package esb_pkg;

  localparam int unsigned SeqW      = 10;
  localparam int unsigned TimeW     = 32;
  localparam int unsigned CntW      = 11;
  localparam int unsigned SumW      = 48;
  localparam int unsigned StatusW   = 3;
  localparam int unsigned CmdW      = 2;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned CfgDataW  = 10;
  localparam int unsigned InDataW   = 48;
  localparam int unsigned OutDataW  = 184;
  localparam int unsigned DefSeqDepth = 1024;

  localparam logic [SeqW-1:0]  MaxPacketsRst = 10'd1000;
  localparam logic [TimeW-1:0] MinStart      = 32'd999000;

  typedef enum logic [CmdW-1:0] {
    CMD_SEND    = 2'd0,
    CMD_REPLY   = 2'd1,
    CMD_TIMEOUT = 2'd2
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    STAT_SENT     = 3'd0,
    STAT_ACCEPTED = 3'd1,
    STAT_NOT_SENT = 3'd2,
    STAT_LATE     = 3'd3,
    STAT_DUP      = 3'd4,
    STAT_TIMEOUT  = 3'd5,
    STAT_RANGE    = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    MARK_NONE     = 2'd0,
    MARK_ACCEPTED = 2'd1,
    MARK_TIMEOUT  = 2'd2
  } mark_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MAX_PACKETS   = 1'b0,
    REG_MARK_TIMEOUTS = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_LOOK = 3'b010,
    ST_POST = 3'b100
  } state_e;

  typedef struct packed {
    logic  sent;
    mark_e mark;
  } flags_t;

  typedef struct packed {
    logic stamp_we;
    logic flag_we;
  } tbl_wr_t;

  typedef struct packed {
    logic sent_inc;
    logic rcvd_inc;
    logic late_inc;
    logic rtt_valid;
  } stat_upd_t;

  typedef struct packed {
    logic [TimeW-1:0] max;
    logic [TimeW-1:0] min;
    logic [SumW-1:0]  sum;
    logic [CntW-1:0]  late;
    logic [CntW-1:0]  rcvd;
    logic [CntW-1:0]  sent;
  } stats_t;

endpackage

// ===== src/esb_ram.sv =====
module esb_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/esb_track.sv =====
module esb_track #(
  parameter int unsigned SeqDepth = esb_pkg::DefSeqDepth,
  localparam int unsigned AddrW = $clog2(SeqDepth)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      rd_en_i,
  input  logic [AddrW-1:0]          rd_addr_i,
  input  esb_pkg::tbl_wr_t          wr_i,
  input  logic [AddrW-1:0]          wr_addr_i,
  input  logic [esb_pkg::TimeW-1:0] stamp_wdata_i,
  input  esb_pkg::flags_t           flags_wdata_i,
  output logic [esb_pkg::TimeW-1:0] stamp_rdata_o,
  output esb_pkg::flags_t           flags_rdata_o,
  output logic                      ready_o
);

  localparam int unsigned FlagW = $bits(esb_pkg::flags_t);

  logic [AddrW-1:0] clr_addr_q, clr_addr_d;
  logic             clr_busy_q, clr_busy_d;
  logic             flag_we;
  logic [AddrW-1:0] flag_waddr;
  logic [FlagW-1:0] flag_wdata;
  logic [FlagW-1:0] flag_rdata;

  // Sweep the flag table once after reset; stamps stay unwritten.
  always_comb begin
    clr_addr_d = clr_addr_q;
    clr_busy_d = clr_busy_q;
    if (clr_busy_q) begin
      if (clr_addr_q == AddrW'(SeqDepth - 1)) begin
        clr_busy_d = 1'b0;
      end else begin
        clr_addr_d = clr_addr_q + AddrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
      clr_busy_q <= 1'b1;
    end else begin
      clr_addr_q <= clr_addr_d;
      clr_busy_q <= clr_busy_d;
    end
  end

  assign flag_we    = clr_busy_q | wr_i.flag_we;
  assign flag_waddr = clr_busy_q ? clr_addr_q : wr_addr_i;
  assign flag_wdata = clr_busy_q ? '0 : FlagW'(flags_wdata_i);

  esb_ram #(
    .Width(esb_pkg::TimeW),
    .Depth(SeqDepth)
  ) u_stamp_ram (
    .clk_i  (clk_i),
    .we_i   (wr_i.stamp_we),
    .waddr_i(wr_addr_i),
    .wdata_i(stamp_wdata_i),
    .re_i   (rd_en_i),
    .raddr_i(rd_addr_i),
    .rdata_o(stamp_rdata_o)
  );

  esb_ram #(
    .Width(FlagW),
    .Depth(SeqDepth)
  ) u_flag_ram (
    .clk_i  (clk_i),
    .we_i   (flag_we),
    .waddr_i(flag_waddr),
    .wdata_i(flag_wdata),
    .re_i   (rd_en_i),
    .raddr_i(rd_addr_i),
    .rdata_o(flag_rdata)
  );

  assign flags_rdata_o = esb_pkg::flags_t'(flag_rdata);
  assign ready_o       = ~clr_busy_q;

endmodule

// ===== src/esb_stats.sv =====
module esb_stats (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      upd_en_i,
  input  esb_pkg::stat_upd_t        upd_i,
  input  logic [esb_pkg::TimeW-1:0] rtt_i,
  output esb_pkg::stats_t           stats_o
);

  localparam int unsigned SumW = esb_pkg::SumW;

  esb_pkg::stats_t  stats_q, stats_d;
  logic [SumW:0]    sum_ext;

  assign sum_ext = {1'b0, stats_q.sum} + (SumW + 1)'(rtt_i);

  always_comb begin
    stats_d = stats_q;
    if (upd_en_i) begin
      if (upd_i.sent_inc && (stats_q.sent != '1)) begin
        stats_d.sent = stats_q.sent + esb_pkg::CntW'(1);
      end
      if (upd_i.rcvd_inc && (stats_q.rcvd != '1)) begin
        stats_d.rcvd = stats_q.rcvd + esb_pkg::CntW'(1);
      end
      if (upd_i.late_inc && (stats_q.late != '1)) begin
        stats_d.late = stats_q.late + esb_pkg::CntW'(1);
      end
      if (upd_i.rtt_valid) begin
        // saturate the sum at all ones
        stats_d.sum = sum_ext[SumW] ? '1 : sum_ext[SumW-1:0];
        if (rtt_i < stats_q.min) begin
          stats_d.min = rtt_i;
        end
        if (rtt_i > stats_q.max) begin
          stats_d.max = rtt_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stats_q.sent <= '0;
      stats_q.rcvd <= '0;
      stats_q.late <= '0;
      stats_q.sum  <= '0;
      stats_q.min  <= esb_pkg::MinStart;
      stats_q.max  <= '0;
    end else begin
      stats_q <= stats_d;
    end
  end

  assign stats_o = stats_q;

endmodule

// ===== src/echo_reply_scoreboard.sv =====
// Echo request scoreboard: tracks send, reply and timeout events per sequence
// number and keeps round-trip statistics.
// Input stream (s_axis_*): one beat per event, tdata = command, seq, time_us.
// Output stream (m_axis_*): one beat per event with the status, the round-trip
// time of an accepted reply and all counters as they stand after the event.
// Config channel (cfg_*): register index 0 is max_packets, 1 is mark_timeouts;
// write only while no event is in flight. cfg_ready_o is always high.
// Each event passes through ST_IDLE (accept and read the per-sequence tables),
// ST_LOOK (check the entry and write it back) and ST_POST (fold it into the
// statistics and present the result beat), as a single read-modify-write of
// the table memories. No new event is taken before the result is loaded; the
// next event is taken in the cycle after the result is loaded.
// After reset the sequence flag table is swept clear, one entry a cycle, over
// all SeqDepth entries (1024 by default); s_axis_tready stays low meanwhile.
// When the receiver stalls, the result beat holds in the output register; one
// more event can be accepted and checked, then the block waits for the slot.
module echo_reply_scoreboard #(
  parameter int unsigned SeqDepth = esb_pkg::DefSeqDepth
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // [1:0] command, [11:2] seq, [43:12] time_us, [47:44] zero
  input  logic [esb_pkg::InDataW-1:0]  s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // [2:0] status, [34:3] rtt_us, [45:35] sent_total, [56:46] received_total,
  // [67:57] late_total, [115:68] rtt_sum, [147:116] rtt_min,
  // [179:148] rtt_max, [183:180] zero
  output logic [esb_pkg::OutDataW-1:0] m_axis_tdata,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [esb_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [esb_pkg::CfgDataW-1:0] cfg_data_i
);

  `include "echo_reply_scoreboard_defines.svh"

  localparam int unsigned AddrW = $clog2(SeqDepth);
  localparam int unsigned SeqW  = esb_pkg::SeqW;
  localparam int unsigned TimeW = esb_pkg::TimeW;
  localparam int unsigned ExtW  = (AddrW > SeqW) ? AddrW : SeqW;

  esb_pkg::state_e    state_q, state_d;
  logic [esb_pkg::CmdW-1:0] cmd_q;
  logic [SeqW-1:0]    seq_q;
  logic [TimeW-1:0]   time_q;
  logic [SeqW-1:0]    max_packets_q;
  logic               mark_to_q;

  esb_pkg::status_e   pend_status_q, pend_status_d;
  logic [TimeW-1:0]   pend_rtt_q, pend_rtt_d;
  esb_pkg::stat_upd_t pend_upd_q, pend_upd_d;

  esb_pkg::status_e   out_status_q;
  logic [TimeW-1:0]   out_rtt_q;
  logic               m_valid_q;

  logic               in_fire, slot_free, post_fire, tbl_ready, in_range;
  logic [SeqW-1:0]    in_seq;
  logic [ExtW-1:0]    rd_seq_ext, wr_seq_ext;
  logic [AddrW-1:0]   rd_addr, wr_addr;
  esb_pkg::tbl_wr_t   tbl_wr;
  esb_pkg::flags_t    flags_rd, flags_wr;
  logic [TimeW-1:0]   stamp_rd;
  esb_pkg::stats_t    stats;

  assign in_seq    = s_axis_tdata[11:2];
  assign in_fire   = s_axis_tvalid & s_axis_tready;
  assign slot_free = ~m_valid_q | m_axis_tready;
  assign post_fire = (state_q == esb_pkg::ST_POST) & slot_free;

  assign s_axis_tready = (state_q == esb_pkg::ST_IDLE) & tbl_ready;
  assign cfg_ready_o   = 1'b1;

  assign rd_seq_ext = ExtW'(in_seq);
  assign rd_addr    = rd_seq_ext[AddrW-1:0];
  assign wr_seq_ext = ExtW'(seq_q);
  assign wr_addr    = wr_seq_ext[AddrW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_packets_q <= esb_pkg::MaxPacketsRst;
      mark_to_q     <= 1'b1;
    end else if (cfg_valid_i) begin
      case (esb_pkg::cfg_reg_e'(cfg_index_i))
        esb_pkg::REG_MAX_PACKETS:   max_packets_q <= cfg_data_i;
        esb_pkg::REG_MARK_TIMEOUTS: mark_to_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Capture the event; the table read launches on the same edge.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q  <= s_axis_tdata[1:0];
      seq_q  <= in_seq;
      time_q <= s_axis_tdata[43:12];
    end
  end

  esb_track #(
    .SeqDepth(SeqDepth)
  ) u_track (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rd_en_i      (in_fire),
    .rd_addr_i    (rd_addr),
    .wr_i         (tbl_wr),
    .wr_addr_i    (wr_addr),
    .stamp_wdata_i(time_q),
    .flags_wdata_i(flags_wr),
    .stamp_rdata_o(stamp_rd),
    .flags_rdata_o(flags_rd),
    .ready_o      (tbl_ready)
  );

  assign in_range = (seq_q <= max_packets_q) && (32'(seq_q) < 32'(SeqDepth));

  // Classify the event against its table entry and write the entry back where it changes.
  always_comb begin
    pend_status_d = esb_pkg::STAT_RANGE;
    pend_rtt_d    = '0;
    pend_upd_d    = '0;
    tbl_wr        = '0;
    flags_wr      = flags_rd;
    if ((state_q == esb_pkg::ST_LOOK) && in_range) begin
      case (esb_pkg::cmd_e'(cmd_q))
        esb_pkg::CMD_SEND: begin
          tbl_wr.stamp_we     = 1'b1;
          tbl_wr.flag_we      = 1'b1;
          flags_wr.sent       = 1'b1;
          pend_upd_d.sent_inc = 1'b1;
          pend_status_d       = esb_pkg::STAT_SENT;
        end
        esb_pkg::CMD_REPLY: begin
          if (!flags_rd.sent) begin
            pend_status_d = esb_pkg::STAT_NOT_SENT;
          end else if (flags_rd.mark == esb_pkg::MARK_TIMEOUT) begin
            pend_upd_d.late_inc = 1'b1;
            pend_status_d       = esb_pkg::STAT_LATE;
          end else if (flags_rd.mark == esb_pkg::MARK_ACCEPTED) begin
            pend_status_d = esb_pkg::STAT_DUP;
          end else begin
            pend_rtt_d           = time_q - stamp_rd;
            tbl_wr.flag_we       = 1'b1;
            flags_wr.mark        = esb_pkg::MARK_ACCEPTED;
            pend_upd_d.rcvd_inc  = 1'b1;
            pend_upd_d.rtt_valid = 1'b1;
            pend_status_d        = esb_pkg::STAT_ACCEPTED;
          end
        end
        esb_pkg::CMD_TIMEOUT: begin
          if (mark_to_q && (flags_rd.mark == esb_pkg::MARK_NONE)) begin
            tbl_wr.flag_we = 1'b1;
            flags_wr.mark  = esb_pkg::MARK_TIMEOUT;
          end
          pend_status_d = esb_pkg::STAT_TIMEOUT;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == esb_pkg::ST_LOOK) begin
      pend_status_q <= pend_status_d;
      pend_rtt_q    <= pend_rtt_d;
      pend_upd_q    <= pend_upd_d;
    end
    if (post_fire) begin
      out_status_q <= pend_status_q;
      out_rtt_q    <= pend_rtt_q;
    end
  end

  esb_stats u_stats (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .upd_en_i(post_fire),
    .upd_i   (pend_upd_q),
    .rtt_i   (pend_rtt_q),
    .stats_o (stats)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      esb_pkg::ST_IDLE: if (in_fire) state_d = esb_pkg::ST_LOOK;
      esb_pkg::ST_LOOK: state_d = esb_pkg::ST_POST;
      esb_pkg::ST_POST: if (slot_free) state_d = esb_pkg::ST_IDLE;
      default:          state_d = esb_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= esb_pkg::ST_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (post_fire) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Statistics only move on post_fire, so they stay stable under the held beat.
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {4'b0, stats.max, stats.min, stats.sum, stats.late,
                          stats.rcvd, stats.sent, out_rtt_q, out_status_q};

  `ESB_ASSERT_NEXT(a_accept_to_look, in_fire, state_q == esb_pkg::ST_LOOK)
  `ESB_ASSERT_NOW(a_wr_only_look, tbl_wr.stamp_we || tbl_wr.flag_we,
                  state_q == esb_pkg::ST_LOOK)
  `ESB_ASSERT_NEXT(a_post_loads_beat, post_fire, m_axis_tvalid)
  `ESB_ASSERT_NOW(a_min_bounded, 1'b1, stats.min <= esb_pkg::MinStart)

endmodule
